[hw/rtl/clle_pkg.sv]
// Shared types and codes for the cursor linked list engine.
// No dependencies.
`timescale 1ns / 1ps

package clle_pkg;

  localparam int LEN_W = 10;
  localparam int POS_W = 10;
  localparam int VAL_W = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        list_length;
  } out_word_t;

endpackage

[hw/rtl/clle_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module clle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/cursor_linked_list_engine_unit.sv]
// Top level of the cursor linked list engine: sequencer over a link RAM and
// a value RAM. Depends on clle_pkg and clle_ram.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_stall   clle_pkg::in_word_t
//   out_     output     out_valid/out_stall clle_pkg::out_word_t
//
// After reset the link RAM is swept once, every slot written, before any word is taken.
// An insert, a delete or a read is bounded by the link walk, one link RAM read per
// list step; a bad position, code 3 or a full store skips the walk.
// One request is in flight at a time; the next word is taken while the last
// result still sits in the output register.
// A stalled output holds the finished result until the output register frees.
`timescale 1ns / 1ps

module cursor_linked_list_engine_unit #(
  parameter int SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clle_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output clle_pkg::out_word_t out_word
);

  import clle_pkg::*;

  localparam int AW   = $clog2(SLOTS);
  localparam int CMPW = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam logic [AW-1:0] FREE_HEAD = '0;
  localparam logic [AW-1:0] DATA_HEAD = AW'(SLOTS - 1);

  typedef enum logic [10:0] {
    S_INIT      = 11'b00000000001,
    S_IDLE      = 11'b00000000010,
    S_INS_FRESH = 11'b00000000100,
    S_INS_NEXT  = 11'b00000001000,
    S_WALK      = 11'b00000010000,
    S_INS_LINK  = 11'b00000100000,
    S_DEL_GONE  = 11'b00001000000,
    S_DEL_FREE  = 11'b00010000000,
    S_DEL_HEAD  = 11'b00100000000,
    S_RD_VAL    = 11'b01000000000,
    S_RESP      = 11'b10000000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           init_idx_r, init_idx_nxt;
  logic [POS_W-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]           prev_r, prev_nxt;
  logic [AW-1:0]           slot_r, slot_nxt;
  in_word_t                req_r, req_nxt;
  logic [1:0]              status_r, status_nxt;
  logic signed [VAL_W-1:0] rdval_r, rdval_nxt;
  logic [AW-1:0]           count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  logic                    link_we;
  logic [AW-1:0]           link_waddr, link_wdata, link_raddr, link_rdata;
  logic                    val_we;
  logic [AW-1:0]           val_waddr, val_raddr;
  logic [VAL_W-1:0]        val_wdata, val_rdata;

  logic [CMPW-1:0]         pos_x, cnt_x;
  logic                    ins_ok, acc_ok, accept;

  function automatic logic [LEN_W-1:0] cnt_len(input logic [AW-1:0] c);
    logic [CMPW-1:0] cw;
    cw = CMPW'(c);
    return cw[LEN_W-1:0];
  endfunction

  clle_ram #(.WIDTH(AW), .DEPTH(SLOTS), .AW(AW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  clle_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS), .AW(AW)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign pos_x  = CMPW'(in_word.position);
  assign cnt_x  = CMPW'(count_r);
  assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
  assign acc_ok = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    state_nxt     = state_r;
    init_idx_nxt  = init_idx_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    req_nxt       = req_r;
    status_nxt    = status_r;
    rdval_nxt     = rdval_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    link_we       = 1'b0;
    link_waddr    = prev_r;
    link_wdata    = '0;
    link_raddr    = prev_r;
    val_we        = 1'b0;
    val_waddr     = slot_r;
    val_wdata     = '0;
    val_raddr     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_idx_r;
        link_wdata = (init_idx_r < AW'(SLOTS - 2)) ? init_idx_r + AW'(1) : '0;
        init_idx_nxt = init_idx_r + AW'(1);
        if (init_idx_r == DATA_HEAD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_word;
          status_nxt = ST_OK;
          rdval_nxt  = '0;
          cnt_nxt    = in_word.position - POS_W'(1);
          prev_nxt   = DATA_HEAD;
          case (in_word.action)
            ACT_INSERT: begin
              if (ins_ok) begin
                link_raddr = FREE_HEAD;
                state_nxt  = S_INS_FRESH;
              end else begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end
            end
            ACT_DELETE, ACT_READ: begin
              if (acc_ok) begin
                link_raddr = DATA_HEAD;
                state_nxt  = S_WALK;
              end else begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_INS_FRESH: begin
        if (link_rdata == FREE_HEAD || link_rdata == DATA_HEAD) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          slot_nxt   = link_rdata;
          link_raddr = link_rdata;
          state_nxt  = S_INS_NEXT;
        end
      end
      S_INS_NEXT: begin
        link_we    = 1'b1;
        link_waddr = FREE_HEAD;
        link_wdata = link_rdata;
        val_we     = 1'b1;
        val_waddr  = slot_r;
        val_wdata  = req_r.value;
        link_raddr = DATA_HEAD;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        if (cnt_r != '0) begin
          prev_nxt   = link_rdata;
          link_raddr = link_rdata;
          cnt_nxt    = cnt_r - POS_W'(1);
        end else begin
          case (req_r.action)
            ACT_INSERT: begin
              link_we    = 1'b1;
              link_waddr = slot_r;
              link_wdata = link_rdata;
              state_nxt  = S_INS_LINK;
            end
            ACT_DELETE: begin
              slot_nxt   = link_rdata;
              link_raddr = link_rdata;
              state_nxt  = S_DEL_GONE;
            end
            default: begin
              val_raddr = link_rdata;
              state_nxt = S_RD_VAL;
            end
          endcase
        end
      end
      S_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = slot_r;
        count_nxt  = count_r + AW'(1);
        state_nxt  = S_RESP;
      end
      S_DEL_GONE: begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = link_rdata;
        link_raddr = FREE_HEAD;
        state_nxt  = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = link_rdata;
        state_nxt  = S_DEL_HEAD;
      end
      S_DEL_HEAD: begin
        link_we    = 1'b1;
        link_waddr = FREE_HEAD;
        link_wdata = slot_r;
        val_we     = 1'b1;
        val_waddr  = slot_r;
        val_wdata  = '0;
        count_nxt  = count_r - AW'(1);
        state_nxt  = S_RESP;
      end
      S_RD_VAL: begin
        rdval_nxt = val_rdata;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.status      = status_r;
          out_word_nxt.read_value  = rdval_r;
          out_word_nxt.list_length = cnt_len(count_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    prev_r     <= prev_nxt;
    slot_r     <= slot_nxt;
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    rdval_r    <= rdval_nxt;
    out_word_r <= out_word_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= AW'(SLOTS - 2))
    else $error("element count exceeds usable slots");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + AW'(1) || count_r == $past(count_r) - AW'(1)))
    else $error("element count moved by more than one");

  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |-> (out_word_r.read_value == '0))
    else $error("failed request returned a value");

endmodule

[verif/testbench.sv]
// Self-checking testbench for cursor_linked_list_engine_unit: a directed script, then random
// insert/delete/read traffic, checked against script rows or a linked-list predictor.
// Depends on clle_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
  import clle_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int FREE_HEAD    = 0;
  localparam int DATA_HEAD    = SLOTS - 1;
  localparam int RANDOM_WORDS = 480;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 1100;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic [10:0]      reps;
    logic             typed;
    out_word_t        want;
  } script_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [POS_W-1:0] slot_link [SLOTS];
  logic [VAL_W-1:0] slot_data [SLOTS];
  int               held;
  out_word_t        expected_words [$];
  script_row_t      script [$];
  int errors = 0, checked = 0, sent = 0, full_rejects = 0, range_rejects = 0, peak_len = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_asks = 0;

  cursor_linked_list_engine_unit #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void clear_lists();
    for (int i = 0; i < SLOTS; i++) begin
      slot_link[i] = (i + 2 < SLOTS) ? POS_W'(i + 1) : '0;
      slot_data[i] = '0;
    end
    held = 0;
  endfunction

  function automatic int slot_before(int pos);
    int node;
    node = DATA_HEAD;
    for (int i = 1; i < pos; i++) node = int'(slot_link[node]);
    return node;
  endfunction

  function automatic out_word_t apply_request(in_word_t w);
    out_word_t r;
    int pos, prev, slot;
    pos = int'(w.position);
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_INSERT: begin
        if (pos < 1 || pos > held + 1) begin
          r.status = ST_RANGE;
        end else begin
          slot = int'(slot_link[FREE_HEAD]);
          if (slot == FREE_HEAD || slot == DATA_HEAD) begin
            r.status = ST_FULL;
          end else begin
            slot_link[FREE_HEAD] = slot_link[slot];
            slot_data[slot] = w.value;
            prev = slot_before(pos);
            slot_link[slot] = slot_link[prev];
            slot_link[prev] = POS_W'(slot);
            held++;
          end
        end
      end
      ACT_DELETE: begin
        if (pos < 1 || pos > held) begin
          r.status = ST_RANGE;
        end else begin
          prev = slot_before(pos);
          slot = int'(slot_link[prev]);
          slot_link[prev] = slot_link[slot];
          slot_link[slot] = slot_link[FREE_HEAD];
          slot_link[FREE_HEAD] = POS_W'(slot);
          slot_data[slot] = '0;
          held--;
        end
      end
      ACT_READ: begin
        if (pos < 1 || pos > held) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = slot_data[slot_link[slot_before(pos)]];
        end
      end
      default: begin
      end
    endcase
    r.list_length = LEN_W'(held);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] act, int pos, logic [31:0] val, int reps,
                                  bit typed, logic [1:0] st, logic [31:0] rd, int len);
    script_row_t row;
    row.action           = act;
    row.position         = POS_W'(pos);
    row.value            = val;
    row.reps             = 11'(reps);
    row.typed            = typed;
    row.want.status      = st;
    row.want.read_value  = rd;
    row.want.list_length = LEN_W'(len);
    script.push_back(row);
  endfunction

  function automatic void note_error(string what, out_word_t want, out_word_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: want st=%0d rd=%0d len=%0d, got st=%0d rd=%0d len=%0d", $time, what,
               want.status, $signed(want.read_value), want.list_length,
               got.status, $signed(got.read_value), got.list_length);
  endfunction

  task automatic offer(in_word_t w, bit typed, out_word_t want);
    out_word_t guess;
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = apply_request(w);
    expected_words.push_back(typed ? want : guess);
    sent++;
    if (guess.status == ST_FULL) full_rejects++;
    if (guess.status == ST_RANGE) range_rejects++;
    if (held > peak_len) peak_len = held;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        note_error("unexpected result", '0, out_word);
      end else begin
        want = expected_words.pop_front();
        checked++;
        if (want.status !== out_word.status || want.read_value !== out_word.read_value ||
            want.list_length !== out_word.list_length)
          note_error("mismatch", want, out_word);
      end
    end
  end

  initial begin : receiver
    int hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 6);
      end
    end
  end

  initial begin : stimulus
    script_row_t row;
    in_word_t    w;
    int          pick, hi;
    clear_lists();
    add_row(ACT_READ,   0,    32'h0,          1,    1, ST_RANGE, 32'h0,          0);
    add_row(ACT_DELETE, 1,    32'h0,          1,    1, ST_RANGE, 32'h0,          0);
    add_row(ACT_INSERT, 2,    32'h1234_5678,  1,    1, ST_RANGE, 32'h0,          0);
    add_row(ACT_INSERT, 0,    32'h1234_5678,  1,    1, ST_RANGE, 32'h0,          0);
    add_row(ACT_NONE,   5,    32'h7FFF_FFFF,  1,    1, ST_OK,    32'h0,          0);
    add_row(ACT_INSERT, 1,    32'h7FFF_FFFF,  1,    1, ST_OK,    32'h0,          1);
    add_row(ACT_INSERT, 1,    32'h8000_0000,  1,    1, ST_OK,    32'h0,          2);
    add_row(ACT_READ,   1,    32'h0,          1,    1, ST_OK,    32'h8000_0000,  2);
    add_row(ACT_READ,   2,    32'h0,          1,    1, ST_OK,    32'h7FFF_FFFF,  2);
    add_row(ACT_READ,   3,    32'h0,          1,    1, ST_RANGE, 32'h0,          2);
    add_row(ACT_INSERT, 3,    32'hFFFF_FFFF,  1,    1, ST_OK,    32'h0,          3);
    add_row(ACT_READ,   1023, 32'h0,          1,    1, ST_RANGE, 32'h0,          3);
    add_row(ACT_DELETE, 2,    32'h0,          1,    1, ST_OK,    32'h0,          2);
    add_row(ACT_READ,   2,    32'h0,          1,    1, ST_OK,    32'hFFFF_FFFF,  2);
    add_row(ACT_INSERT, 1,    32'h0,          40,   0, ST_OK,    32'h0,          0);
    add_row(ACT_READ,   1023, 32'h0,          1,    1, ST_RANGE, 32'h0,          42);
    add_row(ACT_DELETE, 1023, 32'h0,          1,    1, ST_RANGE, 32'h0,          42);
    add_row(ACT_INSERT, 44,   32'h0000_0001,  1,    1, ST_RANGE, 32'h0,          42);
    add_row(ACT_READ,   42,   32'h0,          1,    1, ST_OK,    32'hFFFF_FFFF,  42);
    add_row(ACT_READ,   21,   32'h0,          1,    0, ST_OK,    32'h0,          0);
    add_row(ACT_DELETE, 1,    32'h0,          42,   0, ST_OK,    32'h0,          0);
    add_row(ACT_READ,   1,    32'h0,          1,    1, ST_RANGE, 32'h0,          0);
    add_row(ACT_NONE,   1023, 32'hFFFF_FFFF,  1,    1, ST_OK,    32'h0,          0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      row = script[i];
      for (int k = 0; k < row.reps; k++) begin
        w.action   = row.action;
        w.position = row.position;
        w.value    = (row.reps > 1) ? $urandom : row.value;
        offer(w, row.typed, row.want);
      end
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 250 && n < 350);
      if (n == 150) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
      end
      if (n == 450) hold_asks++;
      pick = $urandom_range(0, 99);
      if (pick < 40) w.action = ACT_INSERT;
      else if (pick < 65) w.action = ACT_DELETE;
      else if (pick < 95) w.action = ACT_READ;
      else w.action = ACT_NONE;
      if (held > 48 && w.action == ACT_INSERT && $urandom_range(0, 1)) w.action = ACT_DELETE;
      hi = (w.action == ACT_INSERT) ? held + 1 : held;
      pick = $urandom_range(0, 99);
      if (pick < 8) w.position = POS_W'($urandom_range(0, 1023));
      else if (pick < 14) w.position = POS_W'(hi + 1);
      else if (pick < 20 || hi == 0) w.position = POS_W'(hi);
      else w.position = POS_W'($urandom_range(1, hi));
      w.value = $urandom;
      offer(w, 1'b0, '0);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d bad positions, %0d full-store rejects.",
             sent, range_rejects, full_rejects);
    $display("Peak list length %0d, %0d results compared.", peak_len, checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/clle_pkg.sv
hw/rtl/clle_ram.sv
hw/rtl/cursor_linked_list_engine_unit.sv
verif/testbench.sv
